// ===== rtl/core/psa_pkg.sv =====
// Shared types, constants and helper functions of the periodic sample aggregator.
package psa_pkg;

  localparam int CountWidth = 12;
  localparam int AccWidth   = 48;
  localparam int ValWidth   = 32;
  localparam int CfgWidth   = 12;
  localparam int IndexWidth = 3;
  localparam int StepWidth  = $clog2(AccWidth);

  localparam logic [1:0] AGG_MAX = 2'd0;
  localparam logic [1:0] AGG_MIN = 2'd1;
  localparam logic [1:0] AGG_AVG = 2'd2;
  localparam logic [1:0] AGG_SUM = 2'd3;

  localparam logic PER_FIXED   = 1'b0;
  localparam logic PER_SLIDING = 1'b1;

  localparam logic [1:0] CAL_HOUR  = 2'd0;
  localparam logic [1:0] CAL_DAY   = 2'd1;
  localparam logic [1:0] CAL_MONTH = 2'd2;

  localparam logic REQ_SAMPLE   = 1'b0;
  localparam logic REQ_ACTIVATE = 1'b1;

  localparam logic [IndexWidth-1:0] REG_SENSOR_ID      = 3'd0;
  localparam logic [IndexWidth-1:0] REG_AGGREGATE_MODE = 3'd1;
  localparam logic [IndexWidth-1:0] REG_PERIOD_MODE    = 3'd2;
  localparam logic [IndexWidth-1:0] REG_CALENDAR_UNIT  = 3'd3;
  localparam logic [IndexWidth-1:0] REG_PERIOD_LENGTH  = 3'd4;
  localparam logic [IndexWidth-1:0] REG_WINDOW_COUNT   = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } psa_state_t;

  typedef struct packed {
    logic                        start;
    logic signed [AccWidth-1:0]  dividend;
    logic [CountWidth-1:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic                        done;
    logic signed [AccWidth-1:0]  quotient;
  } div_rsp_t;

  function automatic logic signed [AccWidth-1:0] sat_acc(input logic signed [AccWidth:0] s);
    logic signed [AccWidth-1:0] r;
    if (s[AccWidth] != s[AccWidth-1]) begin
      r = s[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}} : {1'b0, {(AccWidth-1){1'b1}}};
    end else begin
      r = s[AccWidth-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ValWidth-1:0] sat_val(input logic signed [AccWidth-1:0] v);
    logic signed [ValWidth-1:0] r;
    logic                       fits;
    fits = (&v[AccWidth-1:ValWidth-1]) || !(|v[AccWidth-1:ValWidth-1]);
    if (!fits) begin
      r = v[AccWidth-1] ? {1'b1, {(ValWidth-1){1'b0}}} : {1'b0, {(ValWidth-1){1'b1}}};
    end else begin
      r = v[ValWidth-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/psa_divider.sv =====
// Bit-serial restoring divider: signed accumulator by unsigned sample count, truncating.
module psa_divider (
  input  logic               clk,
  input  logic               rst,
  input  psa_pkg::div_req_t  req,
  output psa_pkg::div_rsp_t  rsp
);
  import psa_pkg::*;

  logic                  busy;
  logic                  done;
  logic [StepWidth-1:0]  step;
  logic                  neg;
  logic [AccWidth-1:0]   quo;
  logic [CountWidth-1:0] rem;
  logic [CountWidth-1:0] dsr;

  logic [CountWidth:0]   rem_sh;
  logic [CountWidth:0]   diff;
  logic                  ge;

  assign rem_sh = {rem, quo[AccWidth-1]};
  assign ge     = rem_sh >= {1'b0, dsr};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !req.start && (step == StepWidth'(AccWidth - 1));
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + StepWidth'(1);
        if (step == StepWidth'(AccWidth - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[AccWidth-1];
      quo <= req.dividend[AccWidth-1] ? AccWidth'(-req.dividend) : AccWidth'(req.dividend);
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= ge ? diff[CountWidth-1:0] : rem_sh[CountWidth-1:0];
      quo <= {quo[AccWidth-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

// ===== rtl/core/periodic_sample_aggregator.sv =====
// Periodic sample aggregator: folds matching samples into max, min, average or sum.
// Activate and ignored samples are taken in their accept cycle; a sample closing
// its period reaches a result via check, emit (max, min, sum) or check, 48-step
// divide, emit (average). Next transaction is accepted when the sequencer is idle.
// The result register frees the input side while a result waits to be taken.
// Synchronous reset: inactive, counters and begin time zero, registers at defaults.
module periodic_sample_aggregator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [psa_pkg::IndexWidth-1:0]        cfg_index,
  input  logic [psa_pkg::CfgWidth-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  req_type,
  input  logic [3:0]                            sensor_type,
  input  logic signed [31:0]                    sample_value,
  input  logic [4:0]                            current_hour,
  input  logic [4:0]                            current_day,
  input  logic [3:0]                            current_month,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [31:0]                    result_value,
  output logic [11:0]                           sample_total
);
  import psa_pkg::*;

  logic [3:0]  sensor_id;
  logic [1:0]  aggregate_mode;
  logic        period_mode;
  logic [1:0]  calendar_unit;
  logic [7:0]  period_length;
  logic [11:0] window_count;

  psa_state_t state, state_next;

  logic signed [AccWidth-1:0] running_value;
  logic [CountWidth-1:0]      sample_count;
  logic                       active_flag;
  logic [4:0]                 begin_hour;
  logic [4:0]                 begin_day;
  logic [3:0]                 begin_month;
  logic [4:0]                 hour_q;
  logic [4:0]                 day_q;
  logic [3:0]                 month_q;
  logic [CountWidth-1:0]      total_q;
  logic signed [ValWidth-1:0] res_q;

  logic                       in_fire;
  logic                       take_sample;
  logic signed [AccWidth-1:0] v_ext;
  logic signed [AccWidth:0]   sum;
  logic signed [AccWidth-1:0] fold_value;
  logic [4:0]                 cal_cur;
  logic [4:0]                 cal_beg;
  logic                       cal_valid;
  logic                       fire;
  logic                       emit_go;

  div_req_t div_req;
  div_rsp_t div_rsp;

  psa_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_id      <= 4'd0;
      aggregate_mode <= AGG_AVG;
      period_mode    <= PER_SLIDING;
      calendar_unit  <= CAL_HOUR;
      period_length  <= 8'd1;
      window_count   <= 12'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SENSOR_ID:      sensor_id      <= cfg_data[3:0];
        REG_AGGREGATE_MODE: aggregate_mode <= cfg_data[1:0];
        REG_PERIOD_MODE:    period_mode    <= cfg_data[0];
        REG_CALENDAR_UNIT:  calendar_unit  <= cfg_data[1:0];
        REG_PERIOD_LENGTH:  period_length  <= cfg_data[7:0];
        REG_WINDOW_COUNT:   window_count   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign in_ready    = (state == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign take_sample = in_fire && (req_type == REQ_SAMPLE) && active_flag &&
                       (sensor_type == sensor_id);

  assign v_ext = {{(AccWidth-32){sample_value[31]}}, sample_value};
  assign sum   = {running_value[AccWidth-1], running_value} + {v_ext[AccWidth-1], v_ext};

  always_comb begin
    fold_value = running_value;
    if (sample_count == '0) begin
      fold_value = v_ext;
    end else begin
      case (aggregate_mode)
        AGG_MAX: if (v_ext > running_value) fold_value = v_ext;
        AGG_MIN: if (v_ext < running_value) fold_value = v_ext;
        default: fold_value = sat_acc(sum);
      endcase
    end
  end

  always_comb begin
    cal_valid = 1'b1;
    cal_cur   = hour_q;
    cal_beg   = begin_hour;
    case (calendar_unit)
      CAL_HOUR: begin
        cal_cur = hour_q;
        cal_beg = begin_hour;
      end
      CAL_DAY: begin
        cal_cur = day_q;
        cal_beg = begin_day;
      end
      CAL_MONTH: begin
        cal_cur = {1'b0, month_q};
        cal_beg = {1'b0, begin_month};
      end
      default: cal_valid = 1'b0;
    endcase
  end

  always_comb begin
    if (period_mode == PER_FIXED) begin
      fire = cal_valid && (cal_cur != cal_beg) &&
             ((cal_cur < cal_beg) || ({3'b000, 5'(cal_cur - cal_beg)} >= period_length));
    end else begin
      fire = 32'(sample_count) >= 32'(window_count);
    end
  end

  assign emit_go = !out_valid || out_ready;

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = running_value;
    div_req.divisor  = sample_count;
    unique case (state)
      ST_IDLE: begin
        if (take_sample) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!fire) begin
          state_next = ST_IDLE;
        end else if (aggregate_mode == AGG_AVG) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      running_value <= '0;
      sample_count <= '0;
      active_flag  <= 1'b0;
      begin_hour   <= '0;
      begin_day    <= '0;
      begin_month  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire && (req_type == REQ_ACTIVATE)) begin
        begin_hour  <= current_hour;
        begin_day   <= current_day;
        begin_month <= current_month;
        active_flag <= 1'b1;
      end
      if (take_sample) begin
        running_value <= fold_value;
        if (sample_count != {CountWidth{1'b1}}) sample_count <= sample_count + CountWidth'(1);
      end
      if (state == ST_CHECK && fire) begin
        sample_count <= '0;
        if (period_mode == PER_FIXED) begin
          begin_hour  <= hour_q;
          begin_day   <= day_q;
          begin_month <= month_q;
        end
      end
      if (state == ST_EMIT && emit_go) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_sample) begin
      hour_q  <= current_hour;
      day_q   <= current_day;
      month_q <= current_month;
    end
    if (state == ST_CHECK && fire) begin
      total_q <= sample_count;
      res_q   <= sat_val(running_value);
    end
    if (state == ST_DIV && div_rsp.done) res_q <= sat_val(div_rsp.quotient);
    if (state == ST_EMIT && emit_go) begin
      result_value <= res_q;
      sample_total <= 12'(total_q);
    end
  end

`ifndef NO_ASSERTIONS
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_rise_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result appeared without an emit step");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> sample_count == '0)
    else $error("sample count not cleared on emission");

  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> total_q != '0)
    else $error("average started with zero samples");
`endif

endmodule
